// ----- hdl/pdob_pkg.sv -----
// Shared types, constants and the sine table builder for the
// phase-distortion oscillator bank. No dependencies.
package pdob_pkg;

  localparam int NUM_OSC    = 256;
  localparam int OSC_BITS   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int TABLE_SIZE = 2048;
  localparam int TBL_BITS   = $clog2(TABLE_SIZE);

  // divider: 64-bit dividend, 33-bit divisor and quotient
  localparam int DIV_N_W = 64;
  localparam int DIV_Q_W = 33;
  localparam logic [5:0] DIV_STEPS = 6'd33;

  // commands (tuser)
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_AMP  = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  // distortion modes
  localparam logic [2:0] MODE_PULSAR = 3'd0;
  localparam logic [2:0] MODE_SAW    = 3'd1;
  localparam logic [2:0] MODE_SQUARE = 3'd2;
  localparam logic [2:0] MODE_PWM    = 3'd3;

  // config register indexes
  localparam logic [1:0] REG_PD_MODE    = 2'd0;
  localparam logic [1:0] REG_PD_DISTORT = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  osc_index;
    logic [15:0] amp_left;
    logic [15:0] amp_right;
    logic [31:0] phase_inc;
    logic [31:0] start_phase;
  } item_t;

  // settings derived from the registers, held stable between ticks
  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] block_size;
    logic [18:0] pul_f;
    logic [30:0] saw_b;
    logic [32:0] saw_den;
    logic [30:0] sq_b;
    logic [32:0] sq_den;
    logic [31:0] pwm_b;
    logic [32:0] pwm_den;
  } pd_cfg_t;

  typedef struct packed {
    logic [39:0] left_sum;
    logic [39:0] right_sum;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AMP_WR, ST_RD, ST_LD, ST_RL, ST_WL, ST_RR, ST_WR,
    ST_PD, ST_WD, ST_TB, ST_IN, ST_MA, ST_DONE, ST_CLR
  } eng_state_t;

  typedef logic signed [15:0] sine_tbl_t [TABLE_SIZE];

  // sin(pi/2 * t), t and result Q30
  function automatic longint unsigned quarter_sine(longint unsigned t);
    longint unsigned t2;
    longint unsigned p;
    t2 = (t * t) >> 30;
    p  = 64'd172271;
    p  = 64'd5026994    - ((t2 * p) >> 30);
    p  = 64'd85569306   - ((t2 * p) >> 30);
    p  = 64'd693598670  - ((t2 * p) >> 30);
    p  = 64'd1686629713 - ((t2 * p) >> 30);
    return (t * p) >> 30;
  endfunction

  function automatic sine_tbl_t build_sine();
    sine_tbl_t       tbl;
    longint unsigned q4;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    int              k;
    for (k = 0; k < TABLE_SIZE; k++) begin
      q4   = longint'(k) * 4;
      quad = q4 / TABLE_SIZE;
      r    = q4 - quad * TABLE_SIZE;
      t    = (r << 30) / TABLE_SIZE;
      if (quad == 1 || quad == 3) t = 64'd1073741824 - t;
      s = quarter_sine(t);
      v = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      tbl[k] = (quad >= 2) ? -$signed(16'(v)) : $signed(16'(v));
    end
    return tbl;
  endfunction

  function automatic logic [OSC_BITS-1:0] osc_addr(logic [7:0] idx);
    return OSC_BITS'(idx);
  endfunction

endpackage

// ----- hdl/pdob_divider.sv -----
// Restoring divider, one quotient bit per cycle, 33 steps.
// Uses pdob_pkg. Quotient must fit in 33 bits.
module pdob_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdob_pkg::DIV_N_W-1:0]  num,
  input  logic [pdob_pkg::DIV_Q_W-1:0]  den,
  output logic                          done,
  output logic [pdob_pkg::DIV_Q_W-1:0]  quo
);
  import pdob_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [33:0]      rem_r;
  logic [32:0]      low_r;
  logic [32:0]      den_r;
  logic [32:0]      quo_r;
  logic [33:0]      trial;
  logic             step_bit;
  logic [33:0]      step_rem;

  assign trial    = {rem_r[32:0], low_r[32]};
  assign step_bit = trial >= {1'b0, den_r};
  assign step_rem = step_bit ? trial - {1'b0, den_r} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {3'b000, num[63:33]};
      low_r <= num[32:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= step_rem;
      low_r <= {low_r[31:0], 1'b0};
      quo_r <= {quo_r[31:0], step_bit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- hdl/pdob_sine_rom.sv -----
// Sine table with two registered read ports.
// Uses pdob_pkg (table contents built at elaboration).
module pdob_sine_rom (
  input  logic                          clk,
  input  logic [pdob_pkg::TBL_BITS-1:0] addr0,
  input  logic [pdob_pkg::TBL_BITS-1:0] addr1,
  output logic signed [15:0]            data0,
  output logic signed [15:0]            data1
);
  import pdob_pkg::*;

  localparam sine_tbl_t SINE = build_sine();

  logic signed [15:0] data0_r;
  logic signed [15:0] data1_r;

  always_ff @(posedge clk) begin
    data0_r <= SINE[addr0];
    data1_r <= SINE[addr1];
  end

  assign data0 = data0_r;
  assign data1 = data1_r;

endmodule

// ----- hdl/pdob_engine.sv -----
// Oscillator state memories and the per-oscillator sequencer.
// Uses pdob_pkg, pdob_divider, pdob_sine_rom.
module pdob_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  pdob_pkg::item_t   item,
  output logic              item_ready,
  input  pdob_pkg::pd_cfg_t cfg,
  output logic              res_valid,
  input  logic              res_ready,
  output pdob_pkg::res_t    res
);
  import pdob_pkg::*;

  eng_state_t state_r, state_nxt;

  // A: {increment, phase}; B: {tgt_r, tgt_l, cur_r, cur_l}
  logic [63:0]          mem_a [NUM_OSC];
  logic [63:0]          mem_b [NUM_OSC];
  logic [63:0]          rd_a_r, rd_b_r;
  logic [63:0]          a_word, b_word;
  logic [OSC_BITS-1:0]  raddr;
  logic                 wr_a_en, wr_b_en;
  logic [OSC_BITS-1:0]  wr_a_addr, wr_b_addr;
  logic [63:0]          wr_a_data, wr_b_data;

  logic [OSC_BITS-1:0]  k_r, idx_r;
  logic [11:0]          tick_r, ri_r;
  logic [12:0]          bsz_r;
  logic                 end_r;
  logic [15:0]          tl_r, tr_r;
  logic [31:0]          phase_r;
  logic [15:0]          cur_lt_r, cur_rt_r, tgt_lt_r, tgt_rt_r;
  logic [15:0]          al_r, ar_r;
  logic [32:0]          base_r, dp_r;
  logic                 neg_r, sqr_r;
  logic signed [15:0]   s_r;
  logic [39:0]          acc_l_r, acc_r_r;

  logic                 accept, in_range;
  logic [12:0]          bsz_c;
  logic [11:0]          ri_c;
  logic                 end_c;
  logic [31:0]          phase_new;

  logic                 div_start, div_done;
  logic [DIV_N_W-1:0]   div_num;
  logic [DIV_Q_W-1:0]   div_den, div_q;
  logic [12:0]          ramp_w;
  logic [29:0]          ramp_l, ramp_r;

  logic                 pd_div;
  logic [DIV_N_W-1:0]   pd_num;
  logic [DIV_Q_W-1:0]   pd_den;
  logic [32:0]          pd_base, pd_dp, fin_dp;
  logic                 pd_neg, pd_sqr;
  logic [50:0]          pul_prod;
  logic [32:0]          saw_comp;
  logic [31:0]          sq_c;

  logic [TBL_BITS-1:0]  ia, ib;
  logic [15:0]          frac;
  logic [16:0]          gfrac;
  logic signed [15:0]   t0, t1;
  logic signed [34:0]   interp, interp_rnd;
  logic signed [32:0]   pl, pr;

  pdob_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign ia = dp_r[31 -: TBL_BITS];
  assign ib = ia + TBL_BITS'(1);
  assign frac = dp_r[31-TBL_BITS -: 16];

  pdob_sine_rom u_rom (
    .clk   (clk),
    .addr0 (ia),
    .addr1 (ib),
    .data0 (t0),
    .data1 (t1)
  );

  // ---- memories ----
  always_ff @(posedge clk) begin
    if (wr_a_en) mem_a[wr_a_addr] <= wr_a_data;
    if (wr_b_en) mem_b[wr_b_addr] <= wr_b_data;
    rd_a_r  <= mem_a[raddr];
    rd_b_r  <= mem_b[raddr];
  end

  assign a_word = rd_a_r;
  assign b_word = rd_b_r;

  // ---- tick setup ----
  assign accept   = item_valid && item_ready;
  assign in_range = int'(item.osc_index) < NUM_OSC;
  always_comb begin
    bsz_c = cfg.block_size;
    if (bsz_c == 13'd0) bsz_c = 13'd1;
    if (bsz_c > 13'd4096) bsz_c = 13'd4096;
    ri_c  = ({1'b0, tick_r} < bsz_c) ? tick_r : 12'(bsz_c - 13'd1);
    end_c = ({1'b0, tick_r} + 13'd1) >= bsz_c;
  end

  assign phase_new = a_word[31:0] + a_word[63:32];

  // ---- ramp numerators ----
  assign ramp_w = bsz_r - {1'b0, ri_r};
  assign ramp_l = 30'(cur_lt_r * ramp_w) + 30'(tgt_lt_r * ri_r);
  assign ramp_r = 30'(cur_rt_r * ramp_w) + 30'(tgt_rt_r * ri_r);

  // ---- phase distortion setup ----
  assign pul_prod = 51'(phase_r) * 51'(cfg.pul_f);
  assign saw_comp = 33'h1_0000_0000 - {1'b0, phase_r};
  assign sq_c     = phase_r + 32'h4000_0000;

  always_comb begin
    pd_div  = 1'b0;
    pd_num  = '0;
    pd_den  = '0;
    pd_base = '0;
    pd_neg  = 1'b0;
    pd_sqr  = 1'b0;
    pd_dp   = {1'b0, phase_r};
    case (cfg.mode)
      MODE_PULSAR: begin
        pd_dp = (pul_prod[50:16] > 35'h1_0000_0000) ? 33'h1_0000_0000
                                                   : pul_prod[48:16];
      end
      MODE_SAW: begin
        pd_div = 1'b1;
        if ({1'b0, phase_r} < {1'b0, cfg.saw_b}) begin
          pd_num = {2'b00, phase_r, 30'd0};
          pd_den = {2'b00, cfg.saw_b};
        end else if (saw_comp <= {2'b00, cfg.saw_b}) begin
          pd_num  = {1'b0, saw_comp, 30'd0};
          pd_den  = {2'b00, cfg.saw_b};
          pd_base = 33'h1_0000_0000;
          pd_neg  = 1'b1;
        end else if (phase_r[31]) begin
          pd_num  = {2'b00, phase_r[30:0], 31'd0};
          pd_den  = cfg.saw_den;
          pd_base = 33'h0_8000_0000;
        end else begin
          pd_num  = {1'b0, 32'h8000_0000 - phase_r, 31'd0};
          pd_den  = cfg.saw_den;
          pd_base = 33'h0_8000_0000;
          pd_neg  = 1'b1;
        end
      end
      MODE_SQUARE: begin
        pd_sqr = 1'b1;
        if ({1'b0, sq_c} < {2'b00, cfg.sq_b}) begin
          pd_dp = 33'h0_C000_0000;          // zero, shifted back a quarter
        end else if (!sq_c[31]) begin
          pd_div = 1'b1;
          pd_num = {sq_c - {1'b0, cfg.sq_b}, 32'd0};
          pd_den = cfg.sq_den;
        end else if (sq_c[30:0] < cfg.sq_b) begin
          pd_dp = 33'h0_4000_0000;          // half, shifted back a quarter
        end else begin
          pd_div  = 1'b1;
          pd_num  = {1'b0, sq_c[30:0] - cfg.sq_b, 32'd0};
          pd_den  = cfg.sq_den;
          pd_base = 33'h0_8000_0000;
        end
      end
      MODE_PWM: begin
        pd_div = 1'b1;
        if (phase_r < cfg.pwm_b) begin
          pd_num = {1'b0, phase_r, 31'd0};
          pd_den = {1'b0, cfg.pwm_b};
        end else begin
          pd_num  = {1'b0, phase_r - cfg.pwm_b, 31'd0};
          pd_den  = cfg.pwm_den;
          pd_base = 33'h0_8000_0000;
        end
      end
      default: pd_dp = {1'b0, phase_r};
    endcase
  end

  always_comb begin
    fin_dp = neg_r ? base_r - div_q : base_r + div_q;
    if (sqr_r) fin_dp = {1'b0, fin_dp[31:0] - 32'h4000_0000};
  end

  // ---- interpolation and products ----
  assign gfrac      = 17'h1_0000 - {1'b0, frac};
  assign interp     = t0 * $signed({1'b0, gfrac}) + t1 * $signed({2'b00, frac});
  assign interp_rnd = interp + 35'sd32768;
  assign pl         = s_r * $signed({1'b0, al_r});
  assign pr         = s_r * $signed({1'b0, ar_r});

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    raddr      = k_r;
    wr_a_en    = 1'b0;
    wr_a_addr  = k_r;
    wr_a_data  = {a_word[63:32], phase_new};
    wr_b_en    = 1'b0;
    wr_b_addr  = k_r;
    wr_b_data  = {b_word[63:32], b_word[63:32]};
    div_start  = 1'b0;
    div_num    = pd_num;
    div_den    = pd_den;
    case (state_r)
      ST_CLR: begin
        // zero one oscillator entry per cycle after reset
        wr_a_en   = 1'b1;
        wr_a_data = '0;
        wr_b_en   = 1'b1;
        wr_b_data = '0;
        state_nxt = (k_r == OSC_BITS'(NUM_OSC - 1)) ? ST_IDLE : ST_CLR;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        raddr      = osc_addr(item.osc_index);
        if (accept) begin
          case (item.cmd)
            CMD_TICK: state_nxt = ST_RD;
            CMD_AMP:  if (in_range) state_nxt = ST_AMP_WR;
            CMD_LOAD: begin
              wr_a_en   = in_range;
              wr_a_addr = osc_addr(item.osc_index);
              wr_a_data = {item.phase_inc, item.start_phase};
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_AMP_WR: begin
        wr_b_en   = 1'b1;
        wr_b_addr = idx_r;
        wr_b_data = {tr_r, tl_r, b_word[31:0]};
        state_nxt = ST_IDLE;
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        wr_a_en   = 1'b1;
        wr_b_en   = end_r;      // block ends: current takes target
        state_nxt = ST_RL;
      end
      ST_RL: begin
        div_start = 1'b1;
        div_num   = 64'(ramp_l);
        div_den   = 33'(bsz_r);
        state_nxt = ST_WL;
      end
      ST_WL: if (div_done) state_nxt = ST_RR;
      ST_RR: begin
        div_start = 1'b1;
        div_num   = 64'(ramp_r);
        div_den   = 33'(bsz_r);
        state_nxt = ST_WR;
      end
      ST_WR: if (div_done) state_nxt = ST_PD;
      ST_PD: begin
        div_start = pd_div;
        state_nxt = pd_div ? ST_WD : ST_TB;
      end
      ST_WD: if (div_done) state_nxt = ST_TB;
      ST_TB: state_nxt = ST_IN;
      ST_IN: state_nxt = ST_MA;
      ST_MA: state_nxt = (k_r == OSC_BITS'(NUM_OSC - 1)) ? ST_DONE : ST_RD;
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (state_r == ST_DONE && res_ready) begin
      tick_r <= end_r ? 12'd0 : tick_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      case (state_r)
        ST_CLR: k_r <= k_r + OSC_BITS'(1);
        ST_IDLE: begin
          idx_r   <= osc_addr(item.osc_index);
          tl_r    <= item.amp_left;
          tr_r    <= item.amp_right;
          bsz_r   <= bsz_c;
          ri_r    <= ri_c;
          end_r   <= end_c;
          k_r     <= '0;
          acc_l_r <= '0;
          acc_r_r <= '0;
        end
        ST_LD: begin
          phase_r  <= phase_new;
          cur_lt_r <= b_word[15:0];
          cur_rt_r <= b_word[31:16];
          tgt_lt_r <= b_word[47:32];
          tgt_rt_r <= b_word[63:48];
        end
        ST_WL: if (div_done) al_r <= div_q[15:0];
        ST_WR: if (div_done) ar_r <= div_q[15:0];
        ST_PD: begin
          dp_r   <= pd_dp;
          base_r <= pd_base;
          neg_r  <= pd_neg;
          sqr_r  <= pd_sqr;
        end
        ST_WD: if (div_done) dp_r <= fin_dp;
        ST_IN: s_r <= interp_rnd[31:16];
        ST_MA: begin
          acc_l_r <= acc_l_r + {{7{pl[32]}}, pl};
          acc_r_r <= acc_r_r + {{7{pr[32]}}, pr};
          k_r     <= k_r + OSC_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  assign res.left_sum  = acc_l_r;
  assign res.right_sum = acc_r_r;

endmodule

// ----- hdl/phase_distortion_oscillator_bank.sv -----
// Phase-distortion wavetable oscillator bank: top level.
// Uses pdob_pkg and pdob_engine (which holds the divider and sine table).
//
// A bank of 256 sine oscillators summed into one stereo word per tick. Each
// input word is a command: load (increment and start phase of one
// oscillator) and amplitude (target left/right of one oscillator) give no
// result; a tick walks all oscillators from the state memories and gives
// one output word with the 40-bit left and right sums. The bank has one
// shared 33-step divider, which each oscillator uses for its two amplitude
// ramps and, in the saw and pwm modes and on the sloped segments of the
// square mode, for the distorted phase (pulsar and the pass-through modes
// skip that step). Input is taken only between commands; a finished sum
// sits in the output register, so the next command is taken while it
// waits. Configuration is written through cfg_* at any time the bank is
// idle; derived distortion constants pass through the ad_r and cfg_r
// registers after a write, and input is held off until they have settled.
// After reset a clearing pass zeroes the state of every oscillator, with
// input held off.

module phase_distortion_oscillator_bank (
  input  logic          clk,
  input  logic          rst_n,
  // input words
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,   // osc_index, amp_left, amp_right, phase_inc,
                                    // start_phase
  input  logic [1:0]    in_tuser,   // cmd
  // result words
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [79:0]   out_tdata,  // left_sum, right_sum
  // register writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import pdob_pkg::*;

  logic [2:0]   pd_mode_r;
  logic [15:0]  pd_distort_r;
  logic [12:0]  block_size_r;
  logic [15:0]  ad_r;
  pd_cfg_t      cfg_r;
  pd_cfg_t      cfg_nxt;
  logic [1:0]   settle_r;
  logic         in_open;
  logic         eng_ready;

  logic [19:0]  ad9;
  logic [39:0]  ad_prod;
  logic [31:0]  dd;
  logic [34:0]  six_dd;
  logic [30:0]  saw_b;
  logic [31:0]  pwm_b;

  item_t        item;
  logic         res_valid;
  logic         res_ready;
  res_t         res;
  logic         out_valid_r;
  res_t         out_data_r;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_mode_r    <= 3'd0;
      pd_distort_r <= 16'd0;
      block_size_r <= 13'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PD_MODE:    pd_mode_r    <= cfg_data[2:0];
        REG_PD_DISTORT: pd_distort_r <= cfg_data;
        REG_BLOCK_SIZE: block_size_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // input held off while the derived constants catch up with a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      settle_r <= 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign in_open   = (settle_r == 2'd0);
  assign in_tready = eng_ready && in_open;

  // ad = floor(0.9 * d): 9d times 2^23/10 rounded up, exact for 9d < 2^20
  assign ad9     = {1'b0, pd_distort_r, 3'b000} + {4'b0000, pd_distort_r};
  assign ad_prod = ad9 * 20'd838861;

  // pulsar slope 1 + 6 d^2
  assign dd     = pd_distort_r * pd_distort_r;
  assign six_dd = {1'b0, dd, 2'b00} + {2'b00, dd, 1'b0};

  // breakpoints and spans of the bent phase segments
  assign saw_b = {17'h1_0000 - {1'b0, ad_r}, 14'd0};
  assign pwm_b = {1'b1, ad_r, 15'd0};

  always_comb begin
    cfg_nxt.mode       = pd_mode_r;
    cfg_nxt.block_size = block_size_r;
    cfg_nxt.pul_f      = 19'h1_0000 + six_dd[34:16];
    cfg_nxt.saw_b      = saw_b;
    cfg_nxt.saw_den    = 33'h1_0000_0000 - {1'b0, saw_b, 1'b0};
    cfg_nxt.sq_b       = {ad_r, 15'd0};
    cfg_nxt.sq_den     = 33'h1_0000_0000 - {1'b0, ad_r, 16'd0};
    cfg_nxt.pwm_b      = pwm_b;
    cfg_nxt.pwm_den    = 33'h1_0000_0000 - {1'b0, pwm_b};
  end

  always_ff @(posedge clk) begin
    ad_r  <= ad_prod[38:23];
    cfg_r <= cfg_nxt;
  end

  // input word unpack
  assign item.cmd         = in_tuser;
  assign item.osc_index   = in_tdata[7:0];
  assign item.amp_left    = in_tdata[23:8];
  assign item.amp_right   = in_tdata[39:24];
  assign item.phase_inc   = in_tdata[71:40];
  assign item.start_phase = in_tdata[103:72];

  pdob_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid && in_open),
    .item       (item),
    .item_ready (eng_ready),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register: holds a finished sum while the engine moves on
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.right_sum, out_data_r.left_sum};

endmodule
